FILE: rtl/dfnp_pkg.sv
// Shared types, widths and constants of the depth frame nearest point unit.
package dfnp_pkg;

    localparam int DEPTH_W     = 16;
    localparam int SCALE_W     = 24;
    localparam int DIM_W       = 11;
    localparam int FOV_W       = 18;
    localparam int POS_W       = 10;
    localparam int DIST_W      = 32;
    localparam int ANG_W       = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 88;
    localparam int PI_W        = 34;
    localparam int DIV_STEPS   = ANG_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [PI_W-1:0]    PI_Q32    = 34'h3_243F_6A88;
    localparam logic [ANG_W-1:0]   ANGLE_MAX = '1;

    localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT = 16'd1500;
    localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 24'd16777;
    localparam logic [DIM_W-1:0]   RST_WIDTH       = 11'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT      = 11'd480;
    localparam logic [FOV_W-1:0]   RST_HFOV        = 18'd67500;
    localparam logic [FOV_W-1:0]   RST_VFOV        = 18'd52600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_LIMIT = 3'd0,
        REG_DEPTH_SCALE = 3'd1,
        REG_FRAME_WIDTH = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_HFOV        = 3'd4,
        REG_VFOV        = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_limit;
        logic [SCALE_W-1:0] depth_scale;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [FOV_W-1:0]   horizontal_fov;
        logic [FOV_W-1:0]   vertical_fov;
    } cfg_t;

    typedef struct packed {
        logic pix;
        logic mul;
        logic sum;
        logic div_init;
        logic div_step;
        logic store;
        logic sel_az;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [POS_W-1:0]  nearest_col;
        logic [POS_W-1:0]  nearest_row;
        logic [ANG_W-1:0]  azimuth;
        logic [ANG_W-1:0]  elevation;
        logic [DIST_W-1:0] distance;
    } result_t;

endpackage

FILE: rtl/dfnp_cfg.sv
// Configuration register file of the depth frame nearest point unit.
module dfnp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dfnp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfnp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dfnp_pkg::cfg_t                   cfg
);
    import dfnp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_limit    <= RST_DEPTH_LIMIT;
            cfg_reg.depth_scale    <= RST_DEPTH_SCALE;
            cfg_reg.frame_width    <= RST_WIDTH;
            cfg_reg.frame_height   <= RST_HEIGHT;
            cfg_reg.horizontal_fov <= RST_HFOV;
            cfg_reg.vertical_fov   <= RST_VFOV;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEPTH_LIMIT:  cfg_reg.depth_limit    <= cfg_data[DEPTH_W-1:0];
                REG_DEPTH_SCALE:  cfg_reg.depth_scale    <= cfg_data[SCALE_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width    <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height   <= cfg_data[DIM_W-1:0];
                REG_HFOV:         cfg_reg.horizontal_fov <= cfg_data[FOV_W-1:0];
                REG_VFOV:         cfg_reg.vertical_fov   <= cfg_data[FOV_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: rtl/dfnp_dp.sv
// Datapath: pixel tracker, shared angle divider and output word register.
module dfnp_dp #(
    parameter int MAX_WIDTH  = dfnp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dfnp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dfnp_pkg::cfg_t                 cfg,
    input  dfnp_pkg::dp_cmd_t              cmd,
    input  logic [dfnp_pkg::DEPTH_W-1:0]   pix_depth,
    input  logic                           pix_last,
    output dfnp_pkg::dp_status_t           status,
    output dfnp_pkg::result_t              result,
    output logic                           result_found
);
    import dfnp_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SZW_W  = $clog2(MAX_WIDTH + 1);
    localparam int SZH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W   = (SZW_W > SZH_W) ? SZW_W : SZH_W;
    localparam int PART_W = SZ_W + 1;
    localparam int NUM_W  = SZ_W + 37;
    localparam int NQ_W   = SZ_W + 19;
    localparam int PROD_W = DEPTH_W + SCALE_W;

    logic [SZ_W-1:0]    w_eff, h_eff;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [DEPTH_W-1:0] best_depth_reg;
    logic [ROW_W-1:0]   best_row_reg;
    logic [COL_W-1:0]   best_col_reg;
    logic               found_reg;
    logic               qualify;
    logic               col_wrap;
    logic               row_wrap;

    logic signed [PART_W-1:0]      part_s;
    logic [SZ_W-1:0]               size_s;
    logic [FOV_W-1:0]              fov_s;
    logic signed [FOV_W:0]         fov_sx;
    logic signed [PART_W+FOV_W:0]  p1_reg;
    logic [SZ_W+FOV_W-1:0]         p2_reg;
    logic [SZ_W+PI_W-1:0]          p3_reg;
    logic [SZ_W-1:0]               size_reg;
    logic [PROD_W-1:0]             dprod;
    logic [DIST_W-1:0]             dist_reg;
    logic [NUM_W-1:0]              num_c;
    logic [NUM_W-1:0]              num_reg;
    logic [NQ_W-1:0]               nq;
    logic                          neg_reg;
    logic                          sat_reg;
    logic [SZ_W-1:0]               rem_reg;
    logic [ANG_W-1:0]              low_reg;
    logic [ANG_W-1:0]              q_reg;
    logic [DIV_CNT_W-1:0]          cnt_reg;
    logic [SZ_W:0]                 trial;
    logic                          trial_ge;
    logic [ANG_W-1:0]              ang;
    logic [ANG_W-1:0]              el_reg;
    logic [ANG_W-1:0]              az_reg;
    result_t                       result_reg;
    logic                          result_found_reg;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = SZ_W'(1);
        else if (32'(cfg.frame_width) > MAX_WIDTH)
            w_eff = SZ_W'(MAX_WIDTH);
        else
            w_eff = SZ_W'(cfg.frame_width);

        if (cfg.frame_height == '0)
            h_eff = SZ_W'(1);
        else if (32'(cfg.frame_height) > MAX_HEIGHT)
            h_eff = SZ_W'(MAX_HEIGHT);
        else
            h_eff = SZ_W'(cfg.frame_height);
    end

    assign qualify  = (pix_depth != '0) && (pix_depth < cfg.depth_limit);
    assign col_wrap = ((SZ_W+1)'(col_reg) + (SZ_W+1)'(1)) >= (SZ_W+1)'(w_eff);
    assign row_wrap = ((SZ_W+1)'(row_reg) + (SZ_W+1)'(1)) >= (SZ_W+1)'(h_eff);

    // track the nearest qualifying pixel and the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            best_depth_reg <= '1;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            best_depth_reg <= '1;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else if (cmd.pix)
        begin
            if (qualify)
            begin
                found_reg <= 1'b1;
                if (pix_depth < best_depth_reg)
                begin
                    best_depth_reg <= pix_depth;
                    best_row_reg   <= row_reg;
                    best_col_reg   <= col_reg;
                end
            end
            if (!pix_last)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // angle operand select
    always_comb
    begin
        if (cmd.sel_az)
        begin
            part_s = signed'(PART_W'(w_eff) - PART_W'(best_col_reg));
            size_s = w_eff;
            fov_s  = cfg.horizontal_fov;
        end
        else
        begin
            part_s = signed'(PART_W'(best_row_reg));
            size_s = h_eff;
            fov_s  = cfg.vertical_fov;
        end
    end

    assign fov_sx = signed'({1'b0, fov_s});
    assign dprod  = best_depth_reg * cfg.depth_scale;
    assign num_c  = (NUM_W'(p1_reg) << 17) + NUM_W'(p3_reg) - (NUM_W'(p2_reg) << 16);
    assign nq     = num_reg[NQ_W+16:17];
    assign trial  = {rem_reg, low_reg[ANG_W-1]};
    assign trial_ge = trial >= {1'b0, size_reg};

    always_comb
    begin
        priority if (neg_reg)
            ang = '0;
        else if (sat_reg)
            ang = ANGLE_MAX;
        else
            ang = q_reg;
    end

    assign status.div_done = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p1_reg   <= part_s * fov_sx;
            p2_reg   <= size_s * fov_s;
            p3_reg   <= PI_Q32 * size_s;
            size_reg <= size_s;
            dist_reg <= dprod[PROD_W-1 -: DIST_W];
        end
        if (cmd.sum)
            num_reg <= num_c;
        if (cmd.div_init)
        begin
            neg_reg <= num_reg[NUM_W-1];
            sat_reg <= nq >= NQ_W'({size_reg, {ANG_W{1'b0}}});
            rem_reg <= SZ_W'(nq[NQ_W-1:ANG_W]);
            low_reg <= nq[ANG_W-1:0];
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? SZ_W'(trial - {1'b0, size_reg}) : SZ_W'(trial);
            low_reg <= {low_reg[ANG_W-2:0], 1'b0};
            q_reg   <= {q_reg[ANG_W-2:0], trial_ge};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.store)
        begin
            if (cmd.sel_az)
                az_reg <= ang;
            else
                el_reg <= ang;
        end
        if (cmd.load)
        begin
            result_found_reg <= found_reg;
            if (found_reg)
            begin
                result_reg.distance    <= dist_reg;
                result_reg.elevation   <= el_reg;
                result_reg.azimuth     <= az_reg;
                result_reg.nearest_row <= POS_W'(best_row_reg);
                result_reg.nearest_col <= POS_W'(best_col_reg);
            end
            else
            begin
                result_reg <= '0;
            end
        end
    end

    assign result       = result_reg;
    assign result_found = result_found_reg;

endmodule

FILE: rtl/dfnp_ctrl.sv
// Controller state machine: pixel handshake, end-of-frame sequence, output word.
module dfnp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  dfnp_pkg::dp_status_t  status,
    output dfnp_pkg::dp_cmd_t     cmd
);
    import dfnp_pkg::*;

    typedef enum logic [2:0] {
        S_PIX,
        S_MUL,
        S_SUM,
        S_DIVI,
        S_DIV,
        S_STORE,
        S_LOAD
    } state_t;

    state_t state_reg;
    logic   sel_az_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   pix_acc;
    logic   load_ok;
    logic   load_go;

    assign pix_acc = s_tvalid && s_tready_reg;
    assign load_ok = !m_tvalid_reg || m_tready;
    assign load_go = (state_reg == S_LOAD) && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_PIX;
            sel_az_reg   <= 1'b0;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !load_go)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_PIX:
                begin
                    if (pix_acc && s_tlast)
                    begin
                        state_reg    <= S_MUL;
                        sel_az_reg   <= 1'b0;
                        s_tready_reg <= 1'b0;
                    end
                end
                S_MUL:  state_reg <= S_SUM;
                S_SUM:  state_reg <= S_DIVI;
                S_DIVI: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (status.div_done)
                        state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    if (sel_az_reg)
                    begin
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        sel_az_reg <= 1'b1;
                        state_reg  <= S_MUL;
                    end
                end
                S_LOAD:
                begin
                    if (load_ok)
                    begin
                        m_tvalid_reg <= 1'b1;
                        s_tready_reg <= 1'b1;
                        state_reg    <= S_PIX;
                    end
                end
                default:
                begin
                    state_reg    <= S_PIX;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.pix      = pix_acc;
        cmd.mul      = (state_reg == S_MUL);
        cmd.sum      = (state_reg == S_SUM);
        cmd.div_init = (state_reg == S_DIVI);
        cmd.div_step = (state_reg == S_DIV);
        cmd.store    = (state_reg == S_STORE);
        cmd.sel_az   = sel_az_reg;
        cmd.load     = load_go;
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/depth_frame_nearest_point_unit.sv
// Top level of the depth frame nearest point unit.
// Throughput: one pixel word per cycle within a frame.
// The result word goes valid once both angles of a frame are done; s_tready is low from the
// last pixel until then, longer while a previous result word still waits. Each angle takes a
// multiply, a sum, a divider setup, 18 divider steps and a store, then the result loads.
// Reset clears the tracker, raster counters and handshake; configuration registers take their reset values.
module depth_frame_nearest_point_unit #(
    parameter int MAX_WIDTH  = dfnp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dfnp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dfnp_pkg::S_TDATA_W-1:0]   s_tdata,   // depth
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distance (low bits), elevation, azimuth, nearest_row, nearest_col (high bits)
    output logic [dfnp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,   // found
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dfnp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfnp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dfnp_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    dfnp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfnp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dfnp_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .pix_depth    (s_tdata[DEPTH_W-1:0]),
        .pix_last     (s_tlast),
        .status       (status),
        .result       (result),
        .result_found (m_tuser)
    );

    assign m_tdata = result;

endmodule

FILE: rtl/dfnp_checker.sv
// Port checker of the depth frame nearest point unit, bound to the top level.
module dfnp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dfnp_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty frame result carries nonzero fields");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input not held off after last pixel");

    a_pixel_flows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("input stalled inside a frame");

    a_result_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without end-of-frame sequence");

endmodule

bind depth_frame_nearest_point_unit dfnp_checker u_dfnp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
